>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros for the RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// Types, sizes and constants of the dual trimmed-mean insulation voltage
// filter.
// ----------------------------------------------------------------------------
package dtm_pkg;

   // Block length and the divisor of the trimmed sums.
   localparam int SAMPLES_PER_BLOCK = 12;
   localparam int DIVISOR           = SAMPLES_PER_BLOCK - 2;
   localparam int CNT_W             = $clog2(SAMPLES_PER_BLOCK);

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int SCALE_W  = 4;
   localparam int AVG_W    = 16;
   localparam int VOLT_W   = 24;
   localparam int FRAC_W   = 4;

   // Reset values.
   localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(5);
   localparam logic [SAMPLE_W-1:0] MIN_RESET   = {SAMPLE_W{1'b1}};

   // Pack voltage scaling: 5100 * 10000 / 100, then divided by 4096.
   localparam int VOLT_MULT   = 510000;
   localparam int VOLT_MULT_W = $clog2(VOLT_MULT + 1);
   localparam int VOLT_SHIFT  = 12;
   localparam int PAIR_W      = SUM_W + 1;
   localparam int PROD1_W     = PAIR_W + SCALE_W;
   localparam int PROD2_W     = PROD1_W + VOLT_MULT_W;

   // Divider lanes: numerator width and the rounded-up reciprocal of the
   // divisor. With a shift of numerator width plus divisor width, the
   // rounding error of the reciprocal never reaches the next quotient step.
   localparam int DIV_NUM_W     = PROD2_W - VOLT_SHIFT;
   localparam int DIVISOR_W     = $clog2(DIVISOR + 1);
   localparam int DIV_SHIFT     = DIV_NUM_W + DIVISOR_W;
   localparam longint unsigned DIV_RECIP_VAL =
      ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int DIV_RECIP_W   = $clog2(DIV_RECIP_VAL + 1);
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(DIV_RECIP_VAL);
   localparam int DIV_PROD_W    = DIV_NUM_W + DIV_RECIP_W;

   // Queue between front and back.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Input transaction.
   typedef struct packed {
      logic [SAMPLE_W-1:0] pos_sample;
      logic [SAMPLE_W-1:0] neg_sample;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [AVG_W-1:0]  avg_pos;
      logic [AVG_W-1:0]  avg_neg;
      logic [VOLT_W-1:0] total_volt;
   } rsp_type;

   // Statistics of one finished block.
   typedef struct packed {
      logic [SUM_W-1:0]    sum_pos;
      logic [SAMPLE_W-1:0] max_pos;
      logic [SAMPLE_W-1:0] min_pos;
      logic [SUM_W-1:0]    sum_neg;
      logic [SAMPLE_W-1:0] max_neg;
      logic [SAMPLE_W-1:0] min_neg;
   } blk_type;

   // Divider lane control.
   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_MULT,
      BK_DIV,
      BK_OUT
   } bk_state_type;

endpackage

>>> rtl/dtm_front.sv
// ----------------------------------------------------------------------------
// dtm_front
// Accepts sample pairs, keeps the running sum, maximum and minimum of each
// channel, and hands a finished block to the queue.
// ----------------------------------------------------------------------------
module dtm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dtm_pkg::req_type req_data,
   output logic             blk_push,
   output dtm_pkg::blk_type blk_data,
   input  logic             blk_full
);
   import dtm_pkg::*;

   logic [CNT_W-1:0]    count_ff,   count_in;
   logic [SUM_W-1:0]    sum_pos_ff, sum_pos_in, sum_pos_nx;
   logic [SUM_W-1:0]    sum_neg_ff, sum_neg_in, sum_neg_nx;
   logic [SAMPLE_W-1:0] max_pos_ff, max_pos_in, max_pos_nx;
   logic [SAMPLE_W-1:0] min_pos_ff, min_pos_in, min_pos_nx;
   logic [SAMPLE_W-1:0] max_neg_ff, max_neg_in, max_neg_nx;
   logic [SAMPLE_W-1:0] min_neg_ff, min_neg_in, min_neg_nx;
   logic                last_item;
   logic                accept;

   // The last pair of a block needs a free queue slot.
   assign last_item = (count_ff == CNT_W'(SAMPLES_PER_BLOCK - 1));
   assign full      = last_item && blk_full;
   assign accept    = push && !full;

   // Statistics including the incoming pair.
   always_comb begin
      sum_pos_nx = sum_pos_ff + SUM_W'(req_data.pos_sample);
      sum_neg_nx = sum_neg_ff + SUM_W'(req_data.neg_sample);
      max_pos_nx = (req_data.pos_sample > max_pos_ff) ? req_data.pos_sample : max_pos_ff;
      min_pos_nx = (req_data.pos_sample < min_pos_ff) ? req_data.pos_sample : min_pos_ff;
      max_neg_nx = (req_data.neg_sample > max_neg_ff) ? req_data.neg_sample : max_neg_ff;
      min_neg_nx = (req_data.neg_sample < min_neg_ff) ? req_data.neg_sample : min_neg_ff;
   end

   // A finished block goes to the queue on the transaction that ends it.
   assign blk_push = accept && last_item;
   always_comb begin
      blk_data.sum_pos = sum_pos_nx;
      blk_data.max_pos = max_pos_nx;
      blk_data.min_pos = min_pos_nx;
      blk_data.sum_neg = sum_neg_nx;
      blk_data.max_neg = max_neg_nx;
      blk_data.min_neg = min_neg_nx;
   end

   // Update or clear the running statistics.
   always_comb begin
      count_in   = count_ff;
      sum_pos_in = sum_pos_ff;
      sum_neg_in = sum_neg_ff;
      max_pos_in = max_pos_ff;
      min_pos_in = min_pos_ff;
      max_neg_in = max_neg_ff;
      min_neg_in = min_neg_ff;
      if (accept && last_item) begin
         count_in   = '0;
         sum_pos_in = '0;
         sum_neg_in = '0;
         max_pos_in = '0;
         min_pos_in = MIN_RESET;
         max_neg_in = '0;
         min_neg_in = MIN_RESET;
      end else if (accept) begin
         count_in   = count_ff + CNT_W'(1);
         sum_pos_in = sum_pos_nx;
         sum_neg_in = sum_neg_nx;
         max_pos_in = max_pos_nx;
         min_pos_in = min_pos_nx;
         max_neg_in = max_neg_nx;
         min_neg_in = min_neg_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_pos_ff <= '0;
         sum_neg_ff <= '0;
         max_pos_ff <= '0;
         min_pos_ff <= MIN_RESET;
         max_neg_ff <= '0;
         min_neg_ff <= MIN_RESET;
      end else begin
         count_ff   <= count_in;
         sum_pos_ff <= sum_pos_in;
         sum_neg_ff <= sum_neg_in;
         max_pos_ff <= max_pos_in;
         min_pos_ff <= min_pos_in;
         max_neg_ff <= max_neg_in;
         min_neg_ff <= min_neg_in;
      end
   end

endmodule

>>> rtl/dtm_fifo.sv
// ----------------------------------------------------------------------------
// dtm_fifo
// Short queue of finished block statistics between the front and back ends.
// ----------------------------------------------------------------------------
module dtm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  dtm_pkg::blk_type wr_data,
   output logic             wr_full,
   input  logic             rd_en,
   output dtm_pkg::blk_type rd_data,
   output logic             rd_empty
);
   import dtm_pkg::*;

   blk_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff,  count_in;
   logic                   do_wr, do_rd;

   assign wr_full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign rd_empty = (count_ff == '0);
   assign do_wr    = wr_en && !wr_full;
   assign do_rd    = rd_en && !rd_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/dtm_div_lane.sv
// ----------------------------------------------------------------------------
// dtm_div_lane
// Divider by the fixed block divisor: the registered numerator is multiplied
// by the rounded-up reciprocal of the divisor and the top bits are kept.
// ----------------------------------------------------------------------------
module dtm_div_lane (
   input  logic                          clock,
   input  dtm_pkg::div_ctl_type          ctl,
   input  logic [dtm_pkg::DIV_NUM_W-1:0] dividend,
   output logic [dtm_pkg::DIV_NUM_W-1:0] quotient
);
   import dtm_pkg::*;

   logic [DIV_NUM_W-1:0]  num_ff;
   logic [DIV_PROD_W-1:0] prod;
   logic [DIV_NUM_W-1:0]  quo_ff, quo_in;

   // Reciprocal product; the bits above the shift are the quotient.
   assign prod   = DIV_PROD_W'(num_ff) * DIV_PROD_W'(DIV_RECIP);
   assign quo_in = DIV_NUM_W'(prod[DIV_PROD_W-1:DIV_SHIFT]);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         num_ff <= dividend;
      end
      if (ctl.step) begin
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

>>> rtl/dtm_back.sv
// ----------------------------------------------------------------------------
// dtm_back
// Trims each finished block, scales the pack voltage, divides all three
// results and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        blk_empty,
   output logic                        blk_pop,
   input  dtm_pkg::blk_type            blk_data,
   input  logic [dtm_pkg::SCALE_W-1:0] ref_scale,
   input  logic                        pop,
   output logic                        empty,
   output dtm_pkg::rsp_type            rsp_data
);
   import dtm_pkg::*;

   bk_state_type        state_ff, state_in;
   logic [SUM_W-1:0]    tp_ff,    tp_in;
   logic [SUM_W-1:0]    tn_ff,    tn_in;
   logic [PROD1_W-1:0]  prod1_ff, prod1_in;
   logic [PROD2_W-1:0]  prod2;
   logic [PAIR_W-1:0]   pair;
   rsp_type             rsp_ff,   rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                trim_load, scale_load, out_load;
   div_ctl_type         div_ctl;
   logic [DIV_NUM_W-1:0] num_pos, num_neg, num_tot;
   logic [DIV_NUM_W-1:0] quo_pos, quo_neg, quo_tot;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!blk_empty) state_in = BK_SCALE;
         end
         BK_SCALE: state_in = BK_MULT;
         BK_MULT:  state_in = BK_DIV;
         BK_DIV:   state_in = BK_OUT;
         BK_OUT: begin
            if (!rsp_valid_ff || pop) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      trim_load    = 1'b0;
      scale_load   = 1'b0;
      div_ctl.load = 1'b0;
      div_ctl.step = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         BK_IDLE:  trim_load    = !blk_empty;
         BK_SCALE: scale_load   = 1'b1;
         BK_MULT:  div_ctl.load = 1'b1;
         BK_DIV:   div_ctl.step = 1'b1;
         BK_OUT:   out_load     = !rsp_valid_ff || pop;
         default: begin
            trim_load = 1'b0;
         end
      endcase
   end

   assign blk_pop = trim_load;

   // Trimmed sums: drop one maximum and one minimum per channel.
   assign tp_in = blk_data.sum_pos - SUM_W'(blk_data.max_pos) - SUM_W'(blk_data.min_pos);
   assign tn_in = blk_data.sum_neg - SUM_W'(blk_data.max_neg) - SUM_W'(blk_data.min_neg);

   // Reference scaling of the summed channels.
   assign pair     = PAIR_W'(tp_ff) + PAIR_W'(tn_ff);
   assign prod1_in = PROD1_W'(pair) * PROD1_W'(ref_scale);

   // Voltage constant product, then the divide by 4096.
   assign prod2 = PROD2_W'(prod1_ff) * PROD2_W'(VOLT_MULT);

   // Numerators of the three divisions.
   assign num_pos = {{(DIV_NUM_W - SUM_W - FRAC_W){1'b0}}, tp_ff, {FRAC_W{1'b0}}};
   assign num_neg = {{(DIV_NUM_W - SUM_W - FRAC_W){1'b0}}, tn_ff, {FRAC_W{1'b0}}};
   assign num_tot = prod2[PROD2_W-1:VOLT_SHIFT];

   dtm_div_lane u_div_pos (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (num_pos),
      .quotient (quo_pos)
   );

   dtm_div_lane u_div_neg (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (num_neg),
      .quotient (quo_neg)
   );

   dtm_div_lane u_div_tot (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (num_tot),
      .quotient (quo_tot)
   );

   // Result register and its occupancy.
   always_comb begin
      rsp_in.avg_pos    = quo_pos[AVG_W-1:0];
      rsp_in.avg_neg    = quo_neg[AVG_W-1:0];
      rsp_in.total_volt = quo_tot[VOLT_W-1:0];
      rsp_valid_in      = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      if (trim_load) begin
         tp_ff <= tp_in;
         tn_ff <= tn_in;
      end
      if (scale_load) begin
         prod1_ff <= prod1_in;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Sequencer checks.
   `ASSERT_IMPLY(a_pop_only_in_idle, clock, reset, blk_pop, state_ff == BK_IDLE)
   `ASSERT_NEXT(a_mult_starts_div, clock, reset, state_ff == BK_MULT, state_ff == BK_DIV)
   `ASSERT_NEXT(a_div_ends, clock, reset, state_ff == BK_DIV, state_ff == BK_OUT)
   `ASSERT_NEXT(a_out_sets_valid, clock, reset, out_load, rsp_valid_ff)

endmodule

>>> rtl/dual_trimmed_mean_isolation_volt.sv
// ----------------------------------------------------------------------------
// dual_trimmed_mean_isolation_volt
// Trimmed-mean filter of the positive and negative insulation taps with a
// scaled pack voltage output.
// ----------------------------------------------------------------------------
// One sample pair is accepted every clock cycle while full is low. After every
// twelfth pair the block drops the largest and smallest sample of each tap,
// and one result transaction follows: both trimmed means with four fraction
// bits and the scaled pack voltage. The back end trims, applies ref_scale,
// forms the voltage constant product, runs the divider lanes, which multiply
// by the rounded-up reciprocal of the divisor, and loads the result register.
// Finished blocks wait in a two-entry queue, so the input only stalls on the
// last pair of a block while that queue is full and results are not being
// popped. Write ref_scale only while no block is in flight.
// ----------------------------------------------------------------------------
module dual_trimmed_mean_isolation_volt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  dtm_pkg::req_type            req_data,
   output logic                        empty,
   input  logic                        pop,
   output dtm_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [dtm_pkg::SCALE_W-1:0] csr_wdata
);
   import dtm_pkg::*;

   logic [SCALE_W-1:0] ref_scale_ff, ref_scale_in;
   logic               blk_push, blk_full, blk_pop, blk_empty;
   blk_type            blk_wr, blk_rd;

   // Reference scale register.
   assign ref_scale_in = csr_we ? csr_wdata : ref_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_scale_ff <= SCALE_RESET;
      end else begin
         ref_scale_ff <= ref_scale_in;
      end
   end

   dtm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .blk_push (blk_push),
      .blk_data (blk_wr),
      .blk_full (blk_full)
   );

   dtm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (blk_push),
      .wr_data  (blk_wr),
      .wr_full  (blk_full),
      .rd_en    (blk_pop),
      .rd_data  (blk_rd),
      .rd_empty (blk_empty)
   );

   dtm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .blk_empty (blk_empty),
      .blk_pop   (blk_pop),
      .blk_data  (blk_rd),
      .ref_scale (ref_scale_ff),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/tb_dual_trimmed_mean_isolation_volt.sv
// ----------------------------------------------------------------------------
// tb_dual_trimmed_mean_isolation_volt
// Self-checking bench for the dual trimmed-mean insulation voltage filter.
// Sample pairs are pushed in whole blocks of twelve. A scoreboard keeps its
// own running sums, maxima and minima and predicts both trimmed means and
// the scaled pack voltage for each block. Every popped transaction is
// checked field by field against the oldest prediction. The run goes
// through several reference factors (zero and both ends of the range among
// them) and through phases with random idle cycles on either side.
// ----------------------------------------------------------------------------
module tb_dual_trimmed_mean_isolation_volt;
   import dtm_pkg::*;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int BLOCKS_PER_RUN = 15;
   localparam int NUM_PHASES     = 8;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

   // Idle patterns of the two channels.
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Kinds of random blocks.
   typedef enum logic [1:0] {
      BLK_FLAT,
      BLK_EXTREME,
      BLK_RANDOM
   } blk_kind_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts block results and checks popped transactions.
   // -------------------------------------------------------------------------
   class trimmed_mean_board;
      rsp_type             expected_q[$];
      logic [SCALE_W-1:0]  ref_scale;
      logic [3:0]          pair_count;
      logic [SUM_W-1:0]    acc_pos;
      logic [SUM_W-1:0]    acc_neg;
      logic [SAMPLE_W-1:0] hi_pos;
      logic [SAMPLE_W-1:0] lo_pos;
      logic [SAMPLE_W-1:0] hi_neg;
      logic [SAMPLE_W-1:0] lo_neg;
      int                  errors;
      int                  pairs_seen;
      int                  results_checked;

      function new();
         ref_scale       = SCALE_RESET;
         errors          = 0;
         pairs_seen      = 0;
         results_checked = 0;
         clear_block();
      endfunction

      function void clear_block();
         pair_count = '0;
         acc_pos    = '0;
         acc_neg    = '0;
         hi_pos     = '0;
         lo_pos     = MIN_RESET;
         hi_neg     = '0;
         lo_neg     = MIN_RESET;
      endfunction

      function void set_scale(logic [SCALE_W-1:0] value);
         ref_scale = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Fold one accepted pair into the block; predict a result at its end.
      function void note_pair(req_type pair);
         longint unsigned trim_pos;
         longint unsigned trim_neg;
         longint unsigned volt;
         rsp_type         exp_rsp;
         pairs_seen++;
         acc_pos = acc_pos + SUM_W'(pair.pos_sample);
         acc_neg = acc_neg + SUM_W'(pair.neg_sample);
         if (pair.pos_sample > hi_pos) hi_pos = pair.pos_sample;
         if (pair.pos_sample < lo_pos) lo_pos = pair.pos_sample;
         if (pair.neg_sample > hi_neg) hi_neg = pair.neg_sample;
         if (pair.neg_sample < lo_neg) lo_neg = pair.neg_sample;
         pair_count = pair_count + 4'd1;
         if (pair_count < SAMPLES_PER_BLOCK) return;

         // Drop one copy of the largest and one of the smallest sample.
         trim_pos = 64'(acc_pos) - 64'(hi_pos) - 64'(lo_pos);
         trim_neg = 64'(acc_neg) - 64'(hi_neg) - 64'(lo_neg);
         exp_rsp.avg_pos = AVG_W'((trim_pos * 16) / DIVISOR);
         exp_rsp.avg_neg = AVG_W'((trim_neg * 16) / DIVISOR);
         // The pack voltage uses the exact sums, not the rounded averages.
         volt = ((trim_pos + trim_neg) * 64'(ref_scale) * 64'(VOLT_MULT))
                / (64'(4096) * DIVISOR);
         exp_rsp.total_volt = VOLT_W'(volt);
         expected_q.push_back(exp_rsp);
         clear_block();
      endfunction

      function void compare_field(string label, longint unsigned exp_val,
                                  longint unsigned act_val);
         if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, exp_val, act_val);
         end
      endfunction

      // Check one popped result transaction against the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h",
                     $time, got);
            return;
         end
         exp_rsp = expected_q.pop_front();
         results_checked++;
         compare_field("avg_pos", exp_rsp.avg_pos, got.avg_pos);
         compare_field("avg_neg", exp_rsp.avg_neg, got.avg_neg);
         compare_field("total_volt", exp_rsp.total_volt, got.total_volt);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block instance.
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   req_type            req_data;
   logic               empty;
   logic               pop;
   rsp_type            rsp_data;
   logic               csr_we;
   logic [SCALE_W-1:0] csr_wdata;

   trimmed_mean_board board;
   idle_mode_type     idle_mode;
   int                cycle_count;
   int                settings_used;

   dual_trimmed_mean_isolation_volt uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock with a period of 10.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 48;
         IDLE_BOTH:   return $urandom_range(0, 99) < 12;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 48;
         IDLE_BOTH:     return $urandom_range(0, 99) < 12;
         default:       return 1'b0;
      endcase
   endfunction

   // Push one sample pair and wait until the transaction is accepted.
   task automatic send_pair(input logic [SAMPLE_W-1:0] pos_val,
                            input logic [SAMPLE_W-1:0] neg_val);
      req_type pair;
      pair.pos_sample = pos_val;
      pair.neg_sample = neg_val;
      while (sender_idles()) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= pair;
      do @(posedge clock); while (full);
      board.note_pair(pair);
   endtask

   // Wait for all predicted results, then for the back end to settle.
   task automatic drain();
      push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ref_scale(input logic [SCALE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_scale(value);
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(blk_kind_type kind,
                                                       logic [SAMPLE_W-1:0] flat);
      int roll;
      roll = $urandom_range(0, 9);
      case (kind)
         BLK_FLAT:    return (roll == 0) ? SAMPLE_W'($urandom_range(0, 4095)) : flat;
         BLK_EXTREME: return (roll < 5) ? '0 : SAMPLE_MAX;
         default: begin
            if (roll == 0) return '0;
            if (roll == 1) return SAMPLE_MAX;
            return SAMPLE_W'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   // Directed blocks: saturated taps, ties at both ends, mixed extremes.
   task automatic run_directed();
      logic [SAMPLE_W-1:0] mix_pos[SAMPLES_PER_BLOCK] =
         '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd1, 12'd2048,
           12'd2047, 12'd2, 12'd4094, 12'd1365, 12'd2730, 12'd100};
      logic [SAMPLE_W-1:0] mix_neg[SAMPLES_PER_BLOCK] =
         '{12'd4095, 12'd3000, 12'd0, 12'd4095, 12'd5, 12'd5,
           12'd5, 12'd2730, 12'd1365, 12'd4094, 12'd1, 12'd0};
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++) send_pair(SAMPLE_MAX, '0);
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++) send_pair(mix_pos[i], mix_neg[i]);
   endtask

   // Random whole blocks so that every phase starts on a block boundary.
   task automatic run_random(input int blocks);
      blk_kind_type        kind;
      logic [SAMPLE_W-1:0] flat_pos;
      logic [SAMPLE_W-1:0] flat_neg;
      int                  roll;
      for (int b = 0; b < blocks; b++) begin
         roll     = $urandom_range(0, 9);
         kind     = (roll == 0) ? BLK_FLAT : (roll == 1) ? BLK_EXTREME : BLK_RANDOM;
         flat_pos = SAMPLE_W'($urandom_range(0, 4095));
         flat_neg = SAMPLE_W'($urandom_range(0, 4095));
         for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
            send_pair(pick_sample(kind, flat_pos), pick_sample(kind, flat_neg));
      end
   endtask

   // Result side: pop with random stalls and check each transaction.
   initial begin
      pop <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         pop <= !receiver_stalls();
         @(posedge clock);
         if (pop && !empty) board.check_result(rsp_data);
      end
   end

   // Main sequence.
   initial begin
      logic [SCALE_W-1:0] scale_plan[NUM_PHASES];
      scale_plan    = '{4'd1, 4'd0, 4'd5, 4'd9, 4'd15, 4'd3, 4'd12, 4'd7};
      board         = new();
      idle_mode     = IDLE_NONE;
      settings_used = 0;
      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the top of the reference range.
      write_ref_scale(4'd15);
      run_directed();
      drain();

      // Random phases; each sets a factor and one of the four idle patterns.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_ref_scale((p == NUM_PHASES - 1) ? SCALE_W'($urandom_range(1, 15))
                                               : scale_plan[p]);
         idle_mode = idle_mode_type'(p % 4);
         run_random(BLOCKS_PER_RUN);
         drain();
      end

      if (board.pending() != 0) board.errors++;
      $display("Run covered %0d sample pairs and %0d checked results.",
               board.pairs_seen, board.results_checked);
      $display("It used %0d reference factors and four idle patterns.",
               settings_used);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
